[rtl/interpolating_pwm_audio_pulser_unit_assert.svh]
// Assertion macros shared by the pulser modules.
`ifndef INTERPOLATING_PWM_AUDIO_PULSER_UNIT_ASSERT_SVH
`define INTERPOLATING_PWM_AUDIO_PULSER_UNIT_ASSERT_SVH

// Plain property, sampled on clk and disabled while reset is asserted.
`define IPAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication, sampled on clk and disabled while reset is asserted.
`define IPAP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/ipap_pkg.sv]
// Shared types and constants of the interpolating pulse-width audio pulser.
`default_nettype none

package ipap_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int WORD_W      = 16;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_TWO_PIN_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE2_START = 2'd1;

    // Register reset values.
    localparam logic              TWO_PIN_MODE_RESET = 1'b1;
    localparam logic [WORD_W-1:0] PHASE2_START_RESET = 16'd516;

    // Timer count where the first phase of each tick begins.
    localparam logic [WORD_W-1:0] PHASE_ONE_AT = 16'd4;

    // Offset added after the sample is scaled by 28.
    localparam logic [WORD_W-1:0] SCALE_OFFSET = 16'd8;

    // Settings the tick engine reads on every tick.
    typedef struct packed {
        logic              two_pin_mode;
        logic [WORD_W-1:0] phase2_start;
    } tick_cfg_t;

endpackage

`default_nettype wire

[rtl/ipap_front.sv]
// Front end: accepts sample items and scales them to the level domain.
`default_nettype none

module ipap_front (
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ipap_pkg::SAMPLE_W-1:0] sample_byte,
    input  wire logic                         two_pin_mode,
    input  wire logic                         q_ready,
    output logic                              push,
    output logic [ipap_pkg::WORD_W-1:0]       push_data
);
    import ipap_pkg::*;

    logic [WORD_W-1:0] centered;

    // In two-pin mode the sample becomes 2*s - 256, a signed value around zero.
    always_comb
    begin
        if (two_pin_mode)
        begin
            centered = {{(WORD_W-SAMPLE_W-1){~sample_byte[SAMPLE_W-1]}},
                        ~sample_byte[SAMPLE_W-1], sample_byte[SAMPLE_W-2:0], 1'b0};
        end
        else
        begin
            centered = {{(WORD_W-SAMPLE_W){1'b0}}, sample_byte};
        end
    end

    // Scale by 28 as 32x - 4x, then add the offset; the result fits in 16 bits.
    assign push_data = (centered << 5) - (centered << 2) + SCALE_OFFSET;

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;

endmodule

`default_nettype wire

[rtl/ipap_queue.sv]
// Short queue of scaled samples between the front end and the tick engine.
`default_nettype none

module ipap_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire logic [ipap_pkg::WORD_W-1:0] push_data,
    output logic                             q_ready,
    input  wire logic                        pop,
    output logic                             q_valid,
    output logic [ipap_pkg::WORD_W-1:0]      q_data
);
    import ipap_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    assign q_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "interpolating_pwm_audio_pulser_unit_assert.svh"

    `IPAP_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "queue count above depth")
    `IPAP_ASSERT_IMPLY(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

[rtl/ipap_back.sv]
// Tick engine: advances the level, places the pulses and updates the delta.
`default_nettype none

module ipap_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ipap_pkg::tick_cfg_t         cfg,
    input  wire logic                        q_valid,
    input  wire logic [ipap_pkg::WORD_W-1:0] q_data,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ipap_pkg::WORD_W-1:0]      compare_a,
    output logic [ipap_pkg::WORD_W-1:0]      compare_b,
    output logic [ipap_pkg::WORD_W-1:0]      compare_c,
    output logic [ipap_pkg::WORD_W-1:0]      compare_d,
    output logic                             last_of_pair
);
    import ipap_pkg::*;

    logic              phase_reg;
    logic              phase_next;
    logic [WORD_W-1:0] level_reg;
    logic [WORD_W-1:0] level_next;
    logic [WORD_W-1:0] delta_reg;
    logic [WORD_W-1:0] delta_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] c_reg;
    logic [WORD_W-1:0] d_reg;
    logic              last_reg;

    logic              adv;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] p1;
    logic [WORD_W-1:0] p2;
    logic [WORD_W-1:0] a_val;
    logic [WORD_W-1:0] b_val;
    logic [WORD_W-1:0] c_val;
    logic [WORD_W-1:0] d_val;
    logic [WORD_W:0]   diff;

    // One tick per cycle while an item waits and the output slot is free.
    assign adv = q_valid && (!out_valid_reg || out_ready);
    assign pop = adv && phase_reg;

    // Two level steps, and the new levels taken down to pulse widths.
    always_comb
    begin
        v1 = level_reg + delta_reg;
        v2 = v1 + delta_reg;
        p1 = {{4{v1[WORD_W-1]}}, v1[WORD_W-1:4]};
        p2 = {{4{v2[WORD_W-1]}}, v2[WORD_W-1:4]};
    end

    // Pulse placement: sign-split across the pin pair, or plain on one pin.
    always_comb
    begin
        if (cfg.two_pin_mode)
        begin
            if (p1[WORD_W-1])
            begin
                a_val = PHASE_ONE_AT;
                c_val = PHASE_ONE_AT - p1;
            end
            else
            begin
                a_val = PHASE_ONE_AT + p1;
                c_val = PHASE_ONE_AT;
            end
            if (p2[WORD_W-1])
            begin
                b_val = cfg.phase2_start - p2;
                d_val = cfg.phase2_start;
            end
            else
            begin
                b_val = cfg.phase2_start;
                d_val = cfg.phase2_start + p2;
            end
        end
        else
        begin
            a_val = PHASE_ONE_AT;
            b_val = PHASE_ONE_AT + p1;
            c_val = cfg.phase2_start;
            d_val = cfg.phase2_start + p2;
        end
    end

    // Distance from the final level to the scaled sample, kept at 17 bits.
    assign diff = {q_data[WORD_W-1], q_data} - {v2[WORD_W-1], v2};

    // State and output slot updates.
    always_comb
    begin
        phase_next     = phase_reg;
        level_next     = level_reg;
        delta_next     = delta_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (adv)
        begin
            out_valid_next = 1'b1;
            level_next     = v2;
            phase_next     = !phase_reg;
            if (phase_reg)
            begin
                delta_next = {diff[WORD_W], diff[WORD_W:2]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            level_reg     <= '0;
            delta_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            delta_reg     <= delta_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= a_val;
            b_reg    <= b_val;
            c_reg    <= c_val;
            d_reg    <= d_val;
            last_reg <= phase_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign compare_a    = a_reg;
    assign compare_b    = b_reg;
    assign compare_c    = c_reg;
    assign compare_d    = d_reg;
    assign last_of_pair = last_reg;

`include "interpolating_pwm_audio_pulser_unit_assert.svh"

    `IPAP_ASSERT_IMPLY(a_second_tick_has_item, phase_reg, q_valid,
        "second tick pending without a queued item")
    `IPAP_ASSERT_IMPLY(a_first_result_then_second, out_valid_reg && !last_reg, phase_reg,
        "first result shown but second tick not pending")

endmodule

`default_nettype wire

[rtl/interpolating_pwm_audio_pulser_unit.sv]
// Top level of the interpolating pulse-width audio pulser.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  in       | in_valid / in_ready   | sample_byte
//  out      | out_valid / out_ready | compare_a..compare_d, last_of_pair
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each sample item yields two results, one per cycle while the output is not
// stalled; the rate is set by the single tick unit of the tick engine.
// Each result is registered from its tick; the first result of an item passes
// through the queue entry and the result register when accepted into an empty queue.
// Reset clears the level, the delta, the queue and restores both registers.
// Output stalls hold the result register; the queue keeps taking items until full.
`default_nettype none

module interpolating_pwm_audio_pulser_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [ipap_pkg::SAMPLE_W-1:0]    sample_byte,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ipap_pkg::WORD_W-1:0]           compare_a,
    output logic [ipap_pkg::WORD_W-1:0]           compare_b,
    output logic [ipap_pkg::WORD_W-1:0]           compare_c,
    output logic [ipap_pkg::WORD_W-1:0]           compare_d,
    output logic                                  last_of_pair,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ipap_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ipap_pkg::WORD_W-1:0]      cfg_data
);
    import ipap_pkg::*;

    logic              two_pin_mode_reg;
    logic              two_pin_mode_next;
    logic [WORD_W-1:0] phase2_start_reg;
    logic [WORD_W-1:0] phase2_start_next;
    tick_cfg_t         tick_cfg;
    logic              push;
    logic [WORD_W-1:0] push_data;
    logic              q_ready;
    logic              q_valid;
    logic [WORD_W-1:0] q_data;
    logic              pop;

    assign cfg_ready = 1'b1;

    // Register write decode; unknown indexes are dropped.
    always_comb
    begin
        two_pin_mode_next = two_pin_mode_reg;
        phase2_start_next = phase2_start_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TWO_PIN_MODE: two_pin_mode_next = cfg_data[0];
                CFG_PHASE2_START: phase2_start_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_pin_mode_reg <= TWO_PIN_MODE_RESET;
            phase2_start_reg <= PHASE2_START_RESET;
        end
        else
        begin
            two_pin_mode_reg <= two_pin_mode_next;
            phase2_start_reg <= phase2_start_next;
        end
    end

    assign tick_cfg.two_pin_mode = two_pin_mode_reg;
    assign tick_cfg.phase2_start = phase2_start_reg;

    ipap_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_byte  (sample_byte),
        .two_pin_mode (two_pin_mode_reg),
        .q_ready      (q_ready),
        .push         (push),
        .push_data    (push_data)
    );

    ipap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    ipap_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (tick_cfg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .compare_a    (compare_a),
        .compare_b    (compare_b),
        .compare_c    (compare_c),
        .compare_d    (compare_d),
        .last_of_pair (last_of_pair)
    );

endmodule

`default_nettype wire
